### sv/grid_ray_cell_walk_2d_core_macros.svh
// assertion helpers shared by the checker
`ifndef GRID_RAY_CELL_WALK_2D_CORE_MACROS_SVH
`define GRID_RAY_CELL_WALK_2D_CORE_MACROS_SVH

// same-cycle implication
`define GRCW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GRCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/grcw_pkg.sv
package grcw_pkg;

   localparam int COORD_W       = 16;
   localparam int CELL_IN_W     = 15;
   localparam int DELTA_W       = 16;
   localparam int DEF_MAX_CELLS = 64;
   localparam int DEF_FRAC_BITS = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL_X,
      ST_MUL_Y,
      ST_WALK
   } grcw_state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic mul_x;
      logic mul_y;
      logic step;
   } grcw_cmd_type;

   typedef struct packed {
      logic last;
   } grcw_status_type;

endpackage

### sv/grcw_ctrl.sv
module grcw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output grcw_pkg::grcw_cmd_type   cmd,
   input  grcw_pkg::grcw_status_type status
);
   import grcw_pkg::*;

   grcw_state_type state_ff;
   grcw_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!reset) begin
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_MUL_X;
         end
         ST_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.mul_y = 1'b1;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/grcw_dp.sv
module grcw_dp #(
   parameter int FRAC_BITS = grcw_pkg::DEF_FRAC_BITS,
   parameter int MAX_CELLS = grcw_pkg::DEF_MAX_CELLS
) (
   input  logic                                    clock,
   input  grcw_pkg::grcw_cmd_type                  cmd,
   output grcw_pkg::grcw_status_type               status,
   input  logic signed [grcw_pkg::COORD_W-1:0]     req_start_x,
   input  logic signed [grcw_pkg::COORD_W-1:0]     req_start_y,
   input  logic signed [grcw_pkg::COORD_W-1:0]     req_end_x,
   input  logic signed [grcw_pkg::COORD_W-1:0]     req_end_y,
   input  logic signed [grcw_pkg::CELL_IN_W-1:0]   req_start_cell_x,
   input  logic signed [grcw_pkg::CELL_IN_W-1:0]   req_start_cell_y,
   output logic signed [grcw_pkg::COORD_W-1:0]     rsp_cell_x,
   output logic signed [grcw_pkg::COORD_W-1:0]     rsp_cell_y,
   output logic                                    rsp_last_cell,
   output logic                                    rsp_truncated
);
   import grcw_pkg::*;

   localparam int NUM_W  = FRAC_BITS + 1;
   localparam int CNT_W  = $clog2(MAX_CELLS + 1);
   localparam int SPAN_W = COORD_W + 1;
   localparam int N_W    = COORD_W + 3;
   localparam int PROD_W = NUM_W + DELTA_W;
   localparam int STEP_W = FRAC_BITS + DELTA_W;
   localparam int TIME_W = FRAC_BITS + DELTA_W + CNT_W;
   localparam logic [NUM_W-1:0] ONE = NUM_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic [NUM_W-1:0]   num;
      logic [DELTA_W-1:0] delta;
      logic               move;
      logic               neg;
      logic [SPAN_W-1:0]  span;
   } axis_type;

   function automatic axis_type axis_calc(input logic signed [COORD_W-1:0] a0,
                                          input logic signed [COORD_W-1:0] a1);
      axis_type                  r;
      logic signed [SPAN_W-1:0]  f0;
      logic signed [SPAN_W-1:0]  f1;
      logic signed [SPAN_W-1:0]  diff;
      f0   = SPAN_W'(a0 >>> FRAC_BITS);
      f1   = SPAN_W'(a1 >>> FRAC_BITS);
      diff = SPAN_W'(a1) - SPAN_W'(a0);
      r    = '0;
      if (diff > 0) begin
         r.move  = 1'b1;
         r.delta = DELTA_W'(diff);
         r.num   = ONE - NUM_W'(a0[FRAC_BITS-1:0]);
         r.span  = f1 - f0;
      end else if (diff < 0) begin
         r.move  = 1'b1;
         r.neg   = 1'b1;
         r.delta = DELTA_W'(-diff);
         r.num   = NUM_W'(a0[FRAC_BITS-1:0]);
         r.span  = f0 - f1;
      end
      return r;
   endfunction

   logic signed [COORD_W-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [COORD_W-1:0] cur_x_ff, cur_y_ff;
   logic signed [COORD_W-1:0] cur_x_in, cur_y_in;
   logic [NUM_W-1:0]          nx_ff, ny_ff;
   logic [DELTA_W-1:0]        dx_ff, dy_ff;
   logic                      move_x_ff, neg_x_ff, move_y_ff, neg_y_ff;
   logic [CNT_W-1:0]          cells_left_ff;
   logic [CNT_W-1:0]          cells_left_in;
   logic                      trunc_ff;
   logic                      trunc_in;
   logic [TIME_W-1:0]         tx_ff, ty_ff;
   logic [TIME_W-1:0]         tx_in, ty_in;

   axis_type                  ax, ay;
   logic [N_W-1:0]            n_cells;
   logic [NUM_W-1:0]          mul_num;
   logic [DELTA_W-1:0]        mul_d;
   logic [PROD_W-1:0]         prod;
   logic [STEP_W-1:0]         step_x, step_y;
   logic                      y_step;

   assign ax      = axis_calc(x0_ff, x1_ff);
   assign ay      = axis_calc(y0_ff, y1_ff);
   assign n_cells = N_W'(1) + N_W'(ax.span) + N_W'(ay.span);

   assign mul_num = cmd.mul_y ? ny_ff : nx_ff;
   assign mul_d   = cmd.mul_y ? dx_ff : dy_ff;
   assign prod    = PROD_W'(mul_num) * PROD_W'(mul_d);

   assign step_x  = {dy_ff, FRAC_BITS'(0)};
   assign step_y  = {dx_ff, FRAC_BITS'(0)};
   assign y_step  = move_y_ff && (!move_x_ff || (ty_ff < tx_ff));

   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      cells_left_in = cells_left_ff;
      trunc_in      = trunc_ff;
      if (cmd.load) begin
         cur_x_in = COORD_W'(req_start_cell_x);
         cur_y_in = COORD_W'(req_start_cell_y);
      end
      if (cmd.setup) begin
         if (n_cells > N_W'(MAX_CELLS)) begin
            cells_left_in = CNT_W'(MAX_CELLS);
            trunc_in      = 1'b1;
         end else begin
            cells_left_in = CNT_W'(n_cells);
            trunc_in      = 1'b0;
         end
      end
      if (cmd.mul_x) begin
         tx_in = TIME_W'(prod);
      end
      if (cmd.mul_y) begin
         ty_in = TIME_W'(prod);
      end
      if (cmd.step) begin
         cells_left_in = cells_left_ff - CNT_W'(1);
         if (y_step) begin
            cur_y_in = neg_y_ff ? cur_y_ff - COORD_W'(1) : cur_y_ff + COORD_W'(1);
            ty_in    = ty_ff + TIME_W'(step_y);
         end else begin
            if (move_x_ff) begin
               cur_x_in = neg_x_ff ? cur_x_ff - COORD_W'(1) : cur_x_ff + COORD_W'(1);
            end
            tx_in = tx_ff + TIME_W'(step_x);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff <= req_start_x;
         y0_ff <= req_start_y;
         x1_ff <= req_end_x;
         y1_ff <= req_end_y;
      end
      if (cmd.setup) begin
         nx_ff     <= ax.num;
         ny_ff     <= ay.num;
         dx_ff     <= ax.delta;
         dy_ff     <= ay.delta;
         move_x_ff <= ax.move;
         neg_x_ff  <= ax.neg;
         move_y_ff <= ay.move;
         neg_y_ff  <= ay.neg;
      end
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      tx_ff         <= tx_in;
      ty_ff         <= ty_in;
      cells_left_ff <= cells_left_in;
      trunc_ff      <= trunc_in;
   end

   assign status.last   = (cells_left_ff == CNT_W'(1));
   assign rsp_cell_x    = cur_x_ff;
   assign rsp_cell_y    = cur_y_ff;
   assign rsp_last_cell = status.last;
   assign rsp_truncated = trunc_ff;

endmodule

### sv/grid_ray_cell_walk_2d_core.sv
// 2D grid walk: one word gives a segment (start and end, signed fixed point with FRAC_BITS
// fraction bits) and the cell the walk starts in; the block answers with one word per grid
// cell the segment crosses, in walk order, with last_cell on the final one. The run holds
// 1 plus the cell boundaries crossed on each axis, clamped to MAX_CELLS with truncated set on
// every word of a clamped run. Ties between the axes step along x. Crossing times are compared
// exactly as cross-multiplied integers. After a word is accepted the block runs its setup states
// (span decode, then the x and y crossing products on one shared multiplier), then
// emits one cell per cycle while rsp_stall is low; it takes the next word the cycle after the
// last cell goes out.
module grid_ray_cell_walk_2d_core #(
   parameter int FRAC_BITS = grcw_pkg::DEF_FRAC_BITS,
   parameter int MAX_CELLS = grcw_pkg::DEF_MAX_CELLS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [grcw_pkg::COORD_W-1:0]     req_start_x,
   input  logic signed [grcw_pkg::COORD_W-1:0]     req_start_y,
   input  logic signed [grcw_pkg::COORD_W-1:0]     req_end_x,
   input  logic signed [grcw_pkg::COORD_W-1:0]     req_end_y,
   input  logic signed [grcw_pkg::CELL_IN_W-1:0]   req_start_cell_x,
   input  logic signed [grcw_pkg::CELL_IN_W-1:0]   req_start_cell_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [grcw_pkg::COORD_W-1:0]     rsp_cell_x,
   output logic signed [grcw_pkg::COORD_W-1:0]     rsp_cell_y,
   output logic                                    rsp_last_cell,
   output logic                                    rsp_truncated
);
   import grcw_pkg::*;

   grcw_cmd_type    cmd;
   grcw_status_type status;

   grcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   grcw_dp #(
      .FRAC_BITS (FRAC_BITS),
      .MAX_CELLS (MAX_CELLS)
   ) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_start_cell_x (req_start_cell_x),
      .req_start_cell_y (req_start_cell_y),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_last_cell    (rsp_last_cell),
      .rsp_truncated    (rsp_truncated)
   );

endmodule

### sv/grcw_chk.sv
`include "grid_ray_cell_walk_2d_core_macros.svh"

module grcw_chk (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [grcw_pkg::COORD_W-1:0]  rsp_cell_x,
   input logic signed [grcw_pkg::COORD_W-1:0]  rsp_cell_y,
   input logic                                 rsp_last_cell,
   input logic                                 rsp_truncated
);

   // a waiting word holds until taken
   `GRCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_cell_x) && $stable(rsp_cell_y) && $stable(rsp_last_cell) && $stable(rsp_truncated), "stalled result word changed")

   // no new segment while a run is being emitted
   `GRCW_ASSERT_NOW(a_one_run, clock, reset, rsp_valid, req_stall, "input open during a run")

   // setup comes between an accepted word and its first cell
   `GRCW_ASSERT_NEXT(a_setup_gap, clock, reset, req_valid && !req_stall, !rsp_valid, "cell shown right after accept")

   // run ends at the last cell
   `GRCW_ASSERT_NEXT(a_run_end, clock, reset, rsp_valid && !rsp_stall && rsp_last_cell, !rsp_valid && !req_stall, "run continued past last cell")

   // truncated is constant over a run
   `GRCW_ASSERT_NEXT(a_trunc_run, clock, reset, rsp_valid && !rsp_stall && !rsp_last_cell, rsp_valid && (rsp_truncated == $past(rsp_truncated)), "truncated changed within a run")

endmodule

bind grid_ray_cell_walk_2d_core grcw_chk u_chk (.*);

### tb/grid_ray_cell_walk_2d_core_tb.sv
module grid_ray_cell_walk_2d_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = grcw_pkg::DEF_FRAC_BITS;
   localparam int MAX_CELLS = grcw_pkg::DEF_MAX_CELLS;
   localparam longint unsigned ONE_FX = longint'(1) << FRAC_BITS;
   localparam int RANDOM_SEGMENTS = 100;

   typedef struct packed {
      logic signed [grcw_pkg::COORD_W-1:0] cell_x;
      logic signed [grcw_pkg::COORD_W-1:0] cell_y;
      logic                                last_cell;
      logic                                truncated;
   } cell_word_type;

   class cell_walk_board;
      cell_word_type pending[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      // cells spanned on one axis, plus crossing numerator, delta and direction
      function int axis_span(input int a0, input int a1, output longint unsigned num,
                             output longint unsigned delta, output bit moves, output bit neg);
         int f0;
         int f1;
         f0 = a0 >>> FRAC_BITS;
         f1 = a1 >>> FRAC_BITS;
         num = 0;
         delta = 0;
         moves = 1'b0;
         neg = 1'b0;
         if (a1 == a0) begin
            return 0;
         end
         moves = 1'b1;
         if (a1 > a0) begin
            delta = longint'(a1 - a0);
            num = ONE_FX - longint'(a0 & int'(ONE_FX - 1));
            return f1 - f0;
         end
         neg = 1'b1;
         delta = longint'(a0 - a1);
         num = longint'(a0 & int'(ONE_FX - 1));
         return f0 - f1;
      endfunction

      function void note_segment(input logic signed [15:0] sx, input logic signed [15:0] sy,
                                 input logic signed [15:0] ex, input logic signed [15:0] ey,
                                 input logic signed [14:0] cx, input logic signed [14:0] cy);
         longint unsigned nx, ny, dx, dy, tx, ty;
         bit mx, negx, my, negy, clamp, go_y;
         int count, cur_x, cur_y, k;
         cell_word_type w;
         count = 1 + axis_span(int'(sx), int'(ex), nx, dx, mx, negx)
                   + axis_span(int'(sy), int'(ey), ny, dy, my, negy);
         clamp = count > MAX_CELLS;
         if (clamp) begin
            count = MAX_CELLS;
         end
         tx = nx * dy;
         ty = ny * dx;
         cur_x = int'(cx);
         cur_y = int'(cy);
         for (k = 0; k < count; k++) begin
            w.cell_x = cur_x[15:0];
            w.cell_y = cur_y[15:0];
            w.last_cell = (k == count - 1);
            w.truncated = clamp;
            pending.push_back(w);
            if (k == count - 1) begin
               break;
            end
            // ties go along x
            go_y = my && (!mx || ty < tx);
            if (go_y) begin
               cur_y += negy ? -1 : 1;
               ty += ONE_FX * dx;
            end else begin
               if (mx) begin
                  cur_x += negx ? -1 : 1;
               end
               tx += ONE_FX * dy;
            end
         end
      endfunction

      function void check_cell(input cell_word_type got);
         cell_word_type want;
         if (pending.size() == 0) begin
            $error("cell word with no segment pending: x %0d y %0d", got.cell_x, got.cell_y);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.cell_x !== want.cell_x) begin
            $error("cell_x: expected %0d, got %0d", want.cell_x, got.cell_x);
            errors++;
         end
         if (got.cell_y !== want.cell_y) begin
            $error("cell_y: expected %0d, got %0d", want.cell_y, got.cell_y);
            errors++;
         end
         if (got.last_cell !== want.last_cell) begin
            $error("last_cell: expected %0d, got %0d", want.last_cell, got.last_cell);
            errors++;
         end
         if (got.truncated !== want.truncated) begin
            $error("truncated: expected %0d, got %0d", want.truncated, got.truncated);
            errors++;
         end
      endfunction
   endclass

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic signed [grcw_pkg::COORD_W-1:0]    req_start_x = '0;
   logic signed [grcw_pkg::COORD_W-1:0]    req_start_y = '0;
   logic signed [grcw_pkg::COORD_W-1:0]    req_end_x = '0;
   logic signed [grcw_pkg::COORD_W-1:0]    req_end_y = '0;
   logic signed [grcw_pkg::CELL_IN_W-1:0]  req_start_cell_x = '0;
   logic signed [grcw_pkg::CELL_IN_W-1:0]  req_start_cell_y = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic signed [grcw_pkg::COORD_W-1:0]    rsp_cell_x;
   logic signed [grcw_pkg::COORD_W-1:0]    rsp_cell_y;
   logic                                   rsp_last_cell;
   logic                                   rsp_truncated;

   cell_walk_board board = new();
   int idle_max = 3;

   grid_ray_cell_walk_2d_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_start_cell_x (req_start_cell_x),
      .req_start_cell_y (req_start_cell_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_last_cell    (rsp_last_cell),
      .rsp_truncated    (rsp_truncated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clip16(input int v);
      if (v > 32767) begin
         return 32767;
      end
      if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   task automatic send_segment(input int sx, input int sy, input int ex, input int ey,
                               input int cx, input int cy);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_x <= sx[15:0];
      req_start_y <= sy[15:0];
      req_end_x <= ex[15:0];
      req_end_y <= ey[15:0];
      req_start_cell_x <= cx[14:0];
      req_start_cell_y <= cy[14:0];
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_segment(sx[15:0], sy[15:0], ex[15:0], ey[15:0], cx[14:0], cy[14:0]);
   endtask

   task automatic send_random_segment();
      int sx, sy, ex, ey, cx, cy, kind, reach, d;
      kind = $urandom_range(0, 9);
      reach = ($urandom_range(0, 3) == 0) ? 8192 : 1280;
      sx = int'($urandom_range(0, 65535)) - 32768;
      sy = int'($urandom_range(0, 65535)) - 32768;
      if (kind >= 8) begin
         // start on a cell corner
         sx = sx & ~int'(ONE_FX - 1);
         sy = sy & ~int'(ONE_FX - 1);
      end
      case (kind)
         7: begin
            ex = int'($urandom_range(0, 65535)) - 32768;
            ey = int'($urandom_range(0, 65535)) - 32768;
         end
         6: begin
            if ($urandom_range(0, 1) == 1) begin
               ex = sx;
               ey = clip16(sy + int'($urandom_range(0, 2 * reach)) - reach);
            end else begin
               ey = sy;
               ex = clip16(sx + int'($urandom_range(0, 2 * reach)) - reach);
            end
         end
         9: begin
            // exact diagonal through corners
            d = int'(ONE_FX) * int'($urandom_range(1, 5));
            ex = clip16(($urandom_range(0, 1) == 1) ? sx + d : sx - d);
            ey = clip16(($urandom_range(0, 1) == 1) ? sy + d : sy - d);
         end
         default: begin
            ex = clip16(sx + int'($urandom_range(0, 2 * reach)) - reach);
            ey = clip16(sy + int'($urandom_range(0, 2 * reach)) - reach);
         end
      endcase
      cx = sx >>> FRAC_BITS;
      cy = sy >>> FRAC_BITS;
      if ($urandom_range(0, 2) == 0) begin
         cx = int'($urandom_range(0, 32767)) - 16384;
         cy = int'($urandom_range(0, 32767)) - 16384;
      end
      send_segment(sx, sy, ex, ey, cx, cy);
   endtask

   task automatic drain_cells();
      int w;
      cell_word_type got;
      forever begin
         w = $urandom_range(0, idle_max);
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.cell_x = rsp_cell_x;
         got.cell_y = rsp_cell_y;
         got.last_cell = rsp_last_cell;
         got.truncated = rsp_truncated;
         board.check_cell(got);
      end
   endtask

   initial begin
      #5_000_000;
      $display("grid_ray_cell_walk_2d_core_tb failed");
      $finish;
   end

   initial begin
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_cells();
      join_none

      // directed words
      send_segment(100, 100, 100, 100, 0, 0);
      send_segment(-32768, -32768, -32768, -32768, -16384, -16384);
      send_segment(128, 0, 1408, 16, 0, 0);
      send_segment(16, 768, 16, -512, 0, 3);
      send_segment(512, 128, 0, 128, 2, 0);
      send_segment(0, 0, 768, 768, 0, 0);
      send_segment(768, 768, 0, 0, 3, 3);
      send_segment(256, 768, 1024, 0, 1, 3);
      send_segment(-32768, -32768, 32767, 32767, -128, -128);
      send_segment(32767, -32768, -32768, 32767, 127, -128);
      send_segment(128, 128, 63 * 256 + 128, 128, 0, 0);
      send_segment(128, 128, 64 * 256 + 128, 128, 0, 0);
      send_segment(300, -300, -900, 700, 16383, -16384);
      send_segment(-2000, 1500, 900, -1100, 16383, 16383);
      send_segment(16, 16, 32, 240, 0, 0);
      send_segment(0, 0, 2560, 1, 0, 0);
      send_segment(-1, -1, 1, 1, -1, -1);
      send_segment(1, 1, -1, -1, 0, 0);
      send_segment(-256, 0, -256, -1, -1, 0);

      // random words, with calm stretches
      for (n = 0; n < RANDOM_SEGMENTS; n++) begin
         case ((n / 30) % 4)
            0: idle_max = 6;
            1: idle_max = 0;
            2: idle_max = 2;
            default: idle_max = 6;
         endcase
         send_random_segment();
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("grid_ray_cell_walk_2d_core_tb passed");
      end else begin
         $display("grid_ray_cell_walk_2d_core_tb failed");
      end
      $finish;
   end

endmodule
